/* rtl/miu_pkg.sv */
// ----------------------------------------------------------------------------
// miu_pkg: shared types for the modular inverse unit
// Status bundle passed from the shared divide/accumulate unit to the sequencer.
// ----------------------------------------------------------------------------
`default_nettype none

package miu_pkg;

    typedef struct packed {
        logic busy;   // iteration in progress
        logic done;   // one-cycle pulse, results valid
    } t_div_sts;

endpackage : miu_pkg

`default_nettype wire

/* rtl/modular_inverse_unit.sv */
// ----------------------------------------------------------------------------
// modular_inverse_unit: modular inverse by the extended Euclidean algorithm
// Sequencer around one shared bit-serial divide/multiply-accumulate unit.
// ----------------------------------------------------------------------------
// Usage: present value and modulus with i_in_valid; the request is taken when
// o_in_stall is low. The result (o_inverse in 0..modulus-1, o_exists = gcd is
// one) appears with o_out_valid and holds until i_out_stall is low. A zero
// modulus reports no inverse; a value at or above the modulus is reduced first.
// Each division runs in the shared unit at one quotient bit per cycle, with the
// Bezout coefficient update folded into the same pass, and is followed by a
// check state. The unit handles one request at a time; a finished result may
// wait on the output while the next request is accepted.
// ----------------------------------------------------------------------------
`default_nettype none

module modular_inverse_unit #(
    parameter int WORD_BITS = 32
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_in_valid,
    output logic                       o_in_stall,
    input  wire logic [WORD_BITS-1:0]  i_value,
    input  wire logic [WORD_BITS-1:0]  i_modulus,
    output logic                       o_out_valid,
    input  wire logic                  i_out_stall,
    output logic      [WORD_BITS-1:0]  o_inverse,
    output logic                       o_exists
);
    import miu_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE,     // waiting for a request
        S_REDUCE,   // value mod modulus in the shared unit
        S_CHECK,    // remainder zero? else launch next Euclid step
        S_STEP,     // waiting on quotient/coefficient update
        S_FINAL,    // normalize coefficient into 0..modulus-1
        S_DONE      // hand result to output register
    } t_state;

    t_state               r_state;
    logic [WORD_BITS-1:0] r_mod;
    logic [WORD_BITS-1:0] r_prev;     // r_{i}
    logic [WORD_BITS-1:0] r_cur;      // r_{i+1}
    logic [WORD_BITS-1:0] r_s_prev;   // coefficient magnitudes
    logic [WORD_BITS-1:0] r_s_cur;
    logic                 r_odd;      // parity of step count -> coefficient sign
    logic                 r_any;      // at least one step taken
    logic [WORD_BITS-1:0] r_res;
    logic                 r_ok;
    logic                 r_out_valid;
    logic [WORD_BITS-1:0] r_inverse;
    logic                 r_exists;

    // shared unit hookup
    logic                 div_start;
    logic [WORD_BITS-1:0] div_dividend;
    logic [WORD_BITS-1:0] div_divisor;
    logic [WORD_BITS-1:0] div_mult;
    logic [WORD_BITS-1:0] div_addend;
    t_div_sts             div_sts;
    logic [WORD_BITS-1:0] div_rem;
    logic [WORD_BITS-1:0] div_acc;

    logic                 in_accept;
    logic                 out_free;
    logic [WORD_BITS-1:0] s_red;
    logic [WORD_BITS-1:0] n_res;
    logic                 n_ok;

    assign o_in_stall = (r_state != S_IDLE);
    assign in_accept  = i_in_valid && !o_in_stall;
    assign out_free   = !r_out_valid || !i_out_stall;

    // REDUCE: value / modulus, coefficient path idle.
    // CHECK:  r_prev / r_cur, s_next = s_prev + q * s_cur.
    always_comb begin
        div_start    = 1'b0;
        div_dividend = r_prev;
        div_divisor  = r_cur;
        div_mult     = r_s_cur;
        div_addend   = r_s_prev;
        unique case (r_state)
            S_REDUCE: begin
                div_start    = !div_sts.busy && !div_sts.done;
                div_dividend = r_cur;
                div_divisor  = r_prev;
                div_mult     = '0;
                div_addend   = '0;
            end
            S_CHECK: begin
                div_start = (r_cur != '0);
            end
            S_IDLE, S_STEP, S_FINAL, S_DONE: begin
                div_start = 1'b0;
            end
            default: begin
                div_start = 1'b0;
            end
        endcase
    end

    // final normalization: magnitude is at most the modulus, one subtract does
    always_comb begin
        s_red = (r_s_prev >= r_mod) ? (r_s_prev - r_mod) : r_s_prev;
        n_ok  = (r_prev == WORD_BITS'(1));
        priority if (!n_ok || !r_any || s_red == '0) begin
            n_res = '0;
        end else if (r_odd) begin
            n_res = s_red;
        end else begin
            n_res = r_mod - s_red;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            // a new result replaces the one being taken in the same cycle
            if (r_state == S_DONE && out_free) begin
                r_out_valid <= 1'b1;
            end else if (r_out_valid && !i_out_stall) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (in_accept) begin
                        r_mod    <= i_modulus;
                        r_prev   <= i_modulus;
                        r_cur    <= i_value;
                        r_s_prev <= '0;
                        r_s_cur  <= WORD_BITS'(1);
                        r_odd    <= 1'b0;
                        r_any    <= 1'b0;
                        if (i_modulus == '0) begin
                            r_res   <= '0;
                            r_ok    <= 1'b0;
                            r_state <= S_DONE;
                        end else begin
                            r_state <= S_REDUCE;
                        end
                    end
                end
                S_REDUCE: begin
                    if (div_sts.done) begin
                        r_cur   <= div_rem;
                        r_state <= S_CHECK;
                    end
                end
                S_CHECK: begin
                    r_state <= (r_cur == '0) ? S_FINAL : S_STEP;
                end
                S_STEP: begin
                    if (div_sts.done) begin
                        r_prev   <= r_cur;
                        r_cur    <= div_rem;
                        r_s_prev <= r_s_cur;
                        r_s_cur  <= div_acc;
                        r_odd    <= !r_odd;
                        r_any    <= 1'b1;
                        r_state  <= S_CHECK;
                    end
                end
                S_FINAL: begin
                    r_res   <= n_res;
                    r_ok    <= n_ok;
                    r_state <= S_DONE;
                end
                S_DONE: begin
                    if (out_free) begin
                        r_inverse <= r_res;
                        r_exists  <= r_ok;
                        r_state   <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    miu_divstep #(
        .WORD_BITS (WORD_BITS)
    ) u_divstep (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (div_dividend),
        .i_divisor  (div_divisor),
        .i_mult     (div_mult),
        .i_addend   (div_addend),
        .o_sts      (div_sts),
        .o_rem      (div_rem),
        .o_acc      (div_acc)
    );

    assign o_out_valid = r_out_valid;
    assign o_inverse   = r_inverse;
    assign o_exists    = r_exists;

    // ---- assertions ----

    // a new result only comes out of the handoff state
    a_out_from_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> $past(r_state == S_DONE))
        else $error("result appeared outside handoff");

    // no inverse means a zero result
    a_zero_when_none: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_exists) |-> (o_inverse == '0))
        else $error("nonzero inverse flagged as nonexistent");

    // shared unit is never relaunched while iterating
    a_no_restart: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        div_start |-> !div_sts.busy)
        else $error("divider started while busy");

    // the unit only finishes while the sequencer waits for it
    a_done_expected: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        div_sts.done |-> (r_state == S_REDUCE || r_state == S_STEP))
        else $error("divider finished with no waiter");

endmodule : modular_inverse_unit

`default_nettype wire

/* rtl/miu_divstep.sv */
// ----------------------------------------------------------------------------
// miu_divstep: shared bit-serial divide and multiply-accumulate unit
// Restoring division one quotient bit per cycle; the quotient bits are folded
// MSB-first into addend + quotient * multiplicand by the same iteration.
// ----------------------------------------------------------------------------
`default_nettype none

module miu_divstep #(
    parameter int WORD_BITS = 32
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_start,
    input  wire logic [WORD_BITS-1:0]  i_dividend,
    input  wire logic [WORD_BITS-1:0]  i_divisor,
    input  wire logic [WORD_BITS-1:0]  i_mult,
    input  wire logic [WORD_BITS-1:0]  i_addend,
    output miu_pkg::t_div_sts          o_sts,
    output logic      [WORD_BITS-1:0]  o_rem,
    output logic      [WORD_BITS-1:0]  o_acc
);
    import miu_pkg::*;

    localparam int CNT_BITS = $clog2(WORD_BITS);

    logic                 r_busy;
    logic                 r_done;
    logic [CNT_BITS-1:0]  r_cnt;
    logic [WORD_BITS-1:0] r_rem;
    logic [WORD_BITS-1:0] r_dvd;
    logic [WORD_BITS-1:0] r_acc;
    logic [WORD_BITS-1:0] r_divisor;
    logic [WORD_BITS-1:0] r_mult;
    logic [WORD_BITS-1:0] r_addend;

    logic [WORD_BITS:0]   trial;
    logic                 qbit;
    logic [WORD_BITS-1:0] n_rem;
    logic [WORD_BITS-1:0] n_acc;

    // one restoring step; partial products stay below the modulus
    always_comb begin
        trial = {r_rem, r_dvd[WORD_BITS-1]};
        qbit  = (trial >= {1'b0, r_divisor});
        n_rem = qbit ? WORD_BITS'(trial - {1'b0, r_divisor}) : trial[WORD_BITS-1:0];
        n_acc = {r_acc[WORD_BITS-2:0], 1'b0} + (qbit ? r_mult : '0);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start && !r_busy) begin
                r_busy <= 1'b1;
                r_cnt  <= CNT_BITS'(WORD_BITS - 1);
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == '0) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start && !r_busy) begin
            r_rem     <= '0;
            r_acc     <= '0;
            r_dvd     <= i_dividend;
            r_divisor <= i_divisor;
            r_mult    <= i_mult;
            r_addend  <= i_addend;
        end else if (r_busy) begin
            r_rem <= n_rem;
            r_acc <= n_acc;
            r_dvd <= {r_dvd[WORD_BITS-2:0], 1'b0};
        end
    end

    assign o_sts.busy = r_busy;
    assign o_sts.done = r_done;
    assign o_rem      = r_rem;
    assign o_acc      = r_acc + r_addend;

endmodule : miu_divstep

`default_nettype wire

/* tb/sv/modular_inverse_unit_test.sv */
// ----------------------------------------------------------------------------
// modular_inverse_unit_test: self-checking bench for the modular inverse unit
// Sends value/modulus requests with random idle gaps on both channels and
// predicts each inverse with an extended Euclid written in plain SV. Every
// result is checked field by field against the oldest pending prediction.
// ----------------------------------------------------------------------------
module modular_inverse_unit_test;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int WORD_BITS    = 32;
    localparam int IDLE_LIMIT   = 20000; // worst-case request plus stalls
    localparam int DRAIN_CYCLES = 1800;  // one worst-case request after the last result

    typedef logic [WORD_BITS-1:0] word_t;

    typedef struct {
        word_t value;
        word_t modulus;
        word_t inverse;
        logic  exists;
    } inverse_req_t;

    logic  i_clk       = 1'b0;
    logic  i_rst_n     = 1'b0;
    logic  i_in_valid  = 1'b0;
    word_t i_value     = '0;
    word_t i_modulus   = '0;
    logic  i_out_stall = 1'b0;
    logic  o_in_stall;
    logic  o_out_valid;
    word_t o_inverse;
    logic  o_exists;

    inverse_req_t pending_inverses[$];

    int unsigned requests_sent   = 0;
    int unsigned results_checked = 0;
    int unsigned inverses_found  = 0;
    int unsigned mismatches      = 0;
    int unsigned idle_cycles     = 0;
    int unsigned out_hold        = 0;
    bit          no_idle         = 1'b0;

    modular_inverse_unit #(
        .WORD_BITS(WORD_BITS)
    ) u_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_value    (i_value),
        .i_modulus  (i_modulus),
        .o_out_valid(o_out_valid),
        .i_out_stall(i_out_stall),
        .o_inverse  (o_inverse),
        .o_exists   (o_exists)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    // Extended Euclid with the coefficient kept as a magnitude; its sign
    // alternates with the step count, so it never wraps.
    function automatic inverse_req_t calc_inverse(word_t value, word_t modulus);
        logic [63:0]  rem_a, rem_b, rem_n, coef_a, coef_b, coef_n, quot, red;
        int unsigned  steps;
        inverse_req_t req;
        req = '{value: value, modulus: modulus, inverse: '0, exists: 1'b0};
        if (modulus == '0)
            return req;
        rem_a  = modulus;
        rem_b  = value % modulus;
        coef_a = 0;
        coef_b = 1;
        steps  = 0;
        while (rem_b != 0) begin
            quot   = rem_a / rem_b;
            rem_n  = rem_a - quot * rem_b;
            coef_n = coef_a + quot * coef_b;
            rem_a  = rem_b;
            rem_b  = rem_n;
            coef_a = coef_b;
            coef_b = coef_n;
            steps++;
        end
        if (rem_a != 1)
            return req;
        req.exists = 1'b1;
        red = coef_a % modulus;
        if (steps == 0 || red == 0)
            req.inverse = '0;
        else if (steps % 2 == 1)
            req.inverse = red[WORD_BITS-1:0];
        else
            req.inverse = modulus - red[WORD_BITS-1:0];
        return req;
    endfunction

    // Mostly short gaps, a few long ones, none while no_idle is set.
    function automatic int unsigned pick_gap();
        int unsigned roll;
        roll = $urandom_range(0, 99);
        if (no_idle || roll < 50)
            return 0;
        if (roll < 90)
            return $urandom_range(1, 4);
        return $urandom_range(10, 60);
    endfunction

    // Receiver back-pressure: bursts of stall after random free cycles.
    always @(posedge i_clk) begin
        if (out_hold > 0) begin
            i_out_stall <= 1'b1;
            out_hold = out_hold - 1;
        end else begin
            i_out_stall <= 1'b0;
            if ($urandom_range(0, 3) == 0)
                out_hold = pick_gap();
        end
    end

    // Result checker: every accepted result against the oldest prediction.
    always @(posedge i_clk) begin
        inverse_req_t want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (pending_inverses.size() == 0) begin
                $display("%0t: result with no request pending: inverse=%h exists=%b",
                         $time, o_inverse, o_exists);
                mismatches++;
            end else begin
                want = pending_inverses.pop_front();
                if (o_inverse !== want.inverse) begin
                    $display("%0t: inverse of %h mod %h: expected %h, actual %h",
                             $time, want.value, want.modulus, want.inverse, o_inverse);
                    mismatches++;
                end
                if (o_exists !== want.exists) begin
                    $display("%0t: exists for %h mod %h: expected %b, actual %b",
                             $time, want.value, want.modulus, want.exists, o_exists);
                    mismatches++;
                end
                results_checked++;
                if (want.exists)
                    inverses_found++;
            end
        end
    end

    // Watchdog: ends the run when neither channel moves for too long.
    always @(posedge i_clk) begin
        if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= IDLE_LIMIT) begin
            $display("%0t: watchdog, no request or result moved in %0d cycles",
                     $time, IDLE_LIMIT);
            $display("Simulation FAILED");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    // Returns at the accepting edge without touching valid, so the next
    // request can keep it high in the same step.
    task automatic send_request(input word_t value, input word_t modulus);
        int unsigned gap;
        gap = pick_gap();
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_value    <= value;
        i_modulus  <= modulus;
        do @(posedge i_clk); while (o_in_stall !== 1'b0);
        pending_inverses.push_back(calc_inverse(value, modulus));
        requests_sent++;
    endtask

    task automatic wait_all_results();
        i_in_valid <= 1'b0;
        while (pending_inverses.size() != 0) @(posedge i_clk);
    endtask

    task automatic test_special_cases();
        send_request(32'd5, 32'd0);               // zero modulus
        send_request(32'd0, 32'd0);
        send_request(32'hFFFF_FFFF, 32'd1);       // modulus one
        send_request(32'd0, 32'd1);
        send_request(32'd0, 32'd97);              // zero value
        send_request(32'd0, 32'hFFFF_FFFF);
        send_request(32'd3, 32'd7);
        send_request(32'd10, 32'd7);              // value above modulus
        send_request(32'd7, 32'd7);               // reduces to zero
        send_request(32'd6, 32'd9);               // common factor
        send_request(32'd1, 32'd2);
    endtask

    task automatic test_extremes();
        send_request(32'd1, 32'hFFFF_FFFF);
        send_request(32'hFFFF_FFFE, 32'hFFFF_FFFF);
        send_request(32'hFFFF_FFFF, 32'hFFFF_FFFE);
        send_request(32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_request(32'd2, 32'hFFFF_FFFF);
        send_request(32'h8000_0000, 32'hFFFF_FFFB);
        // consecutive Fibonacci numbers: the longest remainder chain
        send_request(32'd2971215073, 32'd1836311903);
        send_request(32'd1836311903, 32'd2971215073);
        send_request(32'd65537, 32'd4294967291);
        send_request(32'hAAAA_AAAA, 32'h5555_5555);
        send_request(32'h5555_5555, 32'hAAAA_AAAA);
    endtask

    task automatic test_random_pairs(input int unsigned count);
        word_t       value, modulus;
        int unsigned factor;
        repeat (count) begin
            case ($urandom_range(0, 9))
                0, 1, 2: begin
                    value   = $urandom();
                    modulus = $urandom();
                end
                3, 4: begin                       // odd modulus, likely coprime
                    value   = $urandom();
                    modulus = $urandom() | 32'd1;
                end
                5: begin
                    value   = $urandom();
                    modulus = $urandom_range(1, 255);
                end
                6: begin                          // value at or above modulus
                    modulus = $urandom_range(1, 32'h7FFF_FFFF);
                    value   = modulus + $urandom_range(0, modulus);
                end
                7: begin                          // shared factor, no inverse
                    factor  = $urandom_range(2, 1000);
                    value   = factor * $urandom_range(0, 32'hFFFF_FFFF / factor);
                    modulus = factor * $urandom_range(1, 32'hFFFF_FFFF / factor);
                end
                default: begin                    // near the top of the range
                    modulus = 32'hFFFF_FFFF - $urandom_range(0, 64);
                    value   = $urandom_range(0, 1) ? word_t'($urandom_range(0, 64))
                                                   : 32'hFFFF_FFFF - $urandom_range(0, 64);
                end
            endcase
            send_request(value, modulus);
        end
    endtask

    task automatic test_small_moduli(input int unsigned count);
        repeat (count) begin
            send_request($urandom_range(0, 3) == 0 ? word_t'($urandom())
                                                   : word_t'($urandom_range(0, 40)),
                         $urandom_range(0, 16));
        end
    endtask

    // Both channels run without idling for a stretch.
    task automatic test_back_to_back(input int unsigned count);
        no_idle = 1'b1;
        test_random_pairs(count);
        no_idle = 1'b0;
    endtask

    // Sender holds off until every pending result is back, then resumes.
    task automatic test_drain_pause(input int unsigned rounds);
        repeat (rounds) begin
            test_random_pairs(8);
            wait_all_results();
        end
    endtask

    initial begin
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_special_cases();
        test_extremes();
        test_random_pairs(210);
        test_back_to_back(40);
        test_drain_pause(5);
        test_small_moduli(70);

        wait_all_results();
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("Sent %0d requests, %0d results checked (%0d with an inverse, %0d without)",
                 requests_sent, results_checked, inverses_found,
                 results_checked - inverses_found);
        $display("Covered zero and unit moduli, reduction, shared factors and full-width values");
        if (mismatches == 0 && pending_inverses.size() == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("%0d mismatches, %0d results missing", mismatches,
                     pending_inverses.size());
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule
